FILE: hw/rtl/lesf_pkg.sv
// ----------------------------------------------------------------------------
// lesf_pkg: shared types and constants of the largest empty square finder
// Item formats, register indexes, status codes and fixed field widths.
// ----------------------------------------------------------------------------
package lesf_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CFG_CHAR_W = 7;
  localparam int unsigned ROWS_W    = 11;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned DEF_MAX_COLS = 1024;
  localparam int unsigned DEF_MAX_ROWS = 1024;

  // Row counter saturates at its all-ones value.
  localparam logic [ROWS_W-1:0] ROWS_SAT = {ROWS_W{1'b1}};

  localparam logic [CFG_CHAR_W-1:0] RST_EMPTY_CHAR    = 7'd46;
  localparam logic [CFG_CHAR_W-1:0] RST_OBSTACLE_CHAR = 7'd111;
  localparam logic [ROWS_W-1:0]     RST_EXPECTED_ROWS = 11'd1;

  typedef enum logic [1:0] {
    REG_EMPTY_CHAR    = 2'd0,
    REG_OBSTACLE_CHAR = 2'd1,
    REG_EXPECTED_ROWS = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_ROW_LEN   = 2'd2,
    ST_ROW_COUNT = 2'd3
  } status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic              row_end;
    logic              map_end;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  best_row;
    logic [POS_W-1:0]  best_col;
    logic [SIZE_W-1:0] best_size;
    status_t           status;
  } out_item_t;

  // Keeps the first error of a map: a later one never overwrites it.
  function automatic status_t latch_err(status_t cur, status_t code);
    latch_err = (cur == ST_OK) ? code : cur;
  endfunction

endpackage

FILE: hw/rtl/largest_empty_square_finder_top.sv
// ----------------------------------------------------------------------------
// largest_empty_square_finder_top: streaming largest empty square search
// Finds the largest obstacle-free square of a character map fed cell by cell.
// ----------------------------------------------------------------------------
// Usage. Cells of the map arrive on the in_ channel in row-major order, one
// item per cell, with row_end on the last cell of each row and map_end on the
// last cell of the map. Exactly one item leaves on the out_ channel for each
// map_end item: the top-left row and column and the side of the largest empty
// square (the first in row-major order on ties) and a status code. When the
// status is not ok, the position and size read as zero.
// Throughput is one cell per cycle. A map_end item passes the compute stage
// register before its result enters the result register. The only path that
// holds the input is the result register: while a result waits under
// out_stall, the block keeps taking cells and stalls its input only when the
// next map end has reached the compute stage and has nowhere to go.
// The figure is set by the line buffer: one synchronous read per cell,
// issued as the cell is accepted, with a bypass from the write of the
// previous cell for one-column maps.
// Reset (rst_n low, synchronous) restores the registers to their defaults and
// clears the counters and status. The line buffer needs no clearing pass: the
// first row of each map never reads it, and later rows read only columns the
// rows above have written.
// Registers (APB, byte address 4*index): empty_char, obstacle_char and
// expected_rows. Write them only while no map is in progress.
// ----------------------------------------------------------------------------
module largest_empty_square_finder_top #(
  parameter int unsigned MAX_COLS = lesf_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Cell input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lesf_pkg::in_item_t                 in_payload,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output lesf_pkg::out_item_t                out_payload,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lesf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lesf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lesf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  // Line buffer address, column counter and square size widths. A size never
  // exceeds the column count, so the column counter width serves both.
  localparam int unsigned AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CW  = $clog2(MAX_COLS + 1);
  localparam int unsigned SZW = CW;
  localparam int unsigned RW  = lesf_pkg::ROWS_W;

  // One cell as it sits in the compute stage.
  typedef struct packed {
    logic [AW-1:0]     col;      // line buffer column
    logic [RW-1:0]     row;      // row index of the cell
    logic              cellv;    // cell lies inside the map limits
    logic              obs;      // obstacle or bad character
    logic              row0;     // first row: nothing above
    logic              rowend;   // row is closed after this cell
    logic              mapend;   // last cell of the map
    lesf_pkg::status_t err;      // final status, meaningful on mapend
    logic              fwd;      // take the above size from fwd_sz
    logic [SZW-1:0]    fwd_sz;
  } stage_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [lesf_pkg::CFG_CHAR_W-1:0] empty_char_r;
  logic [lesf_pkg::CFG_CHAR_W-1:0] obstacle_char_r;
  logic [RW-1:0]                   expected_rows_r;
  lesf_pkg::reg_idx_t              cfg_idx;
  logic                            cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = lesf_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_char_r    <= lesf_pkg::RST_EMPTY_CHAR;
      obstacle_char_r <= lesf_pkg::RST_OBSTACLE_CHAR;
      expected_rows_r <= lesf_pkg::RST_EXPECTED_ROWS;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lesf_pkg::REG_EMPTY_CHAR:    empty_char_r    <= pwdata[lesf_pkg::CFG_CHAR_W-1:0];
        lesf_pkg::REG_OBSTACLE_CHAR: obstacle_char_r <= pwdata[lesf_pkg::CFG_CHAR_W-1:0];
        lesf_pkg::REG_EXPECTED_ROWS: expected_rows_r <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lesf_pkg::REG_EMPTY_CHAR:
        prdata = {{(lesf_pkg::APB_DATA_W-lesf_pkg::CFG_CHAR_W){1'b0}}, empty_char_r};
      lesf_pkg::REG_OBSTACLE_CHAR:
        prdata = {{(lesf_pkg::APB_DATA_W-lesf_pkg::CFG_CHAR_W){1'b0}}, obstacle_char_r};
      lesf_pkg::REG_EXPECTED_ROWS:
        prdata = {{(lesf_pkg::APB_DATA_W-RW){1'b0}}, expected_rows_r};
      default:
        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control
  // --------------------------------------------------------------------------
  logic   a_valid_r;
  stage_t a_r;
  logic   out_valid_r;
  logic   adv;
  logic   in_acc;
  logic   a_fire;
  logic   a_we;

  // The compute stage moves on unless it holds a map end while the result
  // register is still occupied and stalled.
  assign adv      = !(a_valid_r && a_r.mapend && out_valid_r && out_stall);
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;
  assign a_fire   = a_valid_r && adv;
  assign a_we     = a_fire && a_r.cellv;

  // --------------------------------------------------------------------------
  // Front end: counters and error tracking, updated as each item is accepted
  // --------------------------------------------------------------------------
  logic [CW-1:0]     col_cnt_r, col_cnt_nxt;
  logic [RW-1:0]     row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]     frw_r, frw_nxt;
  lesf_pkg::status_t err_r, err_nxt;
  logic              ign_rows, ign_cols, cellv, is_obs, bad_char;
  logic [CW-1:0]     col_after;
  logic [RW-1:0]     row_after;

  always_comb begin
    ign_rows  = 32'(row_cnt_r) >= MAX_ROWS;
    ign_cols  = !ign_rows && (32'(col_cnt_r) >= MAX_COLS);
    cellv     = !ign_rows && !ign_cols;
    is_obs    = in_payload.cell_char == {1'b0, obstacle_char_r};
    bad_char  = !is_obs && (in_payload.cell_char != {1'b0, empty_char_r});

    err_nxt = err_r;
    if (ign_rows) begin
      err_nxt = lesf_pkg::latch_err(err_nxt, lesf_pkg::ST_ROW_COUNT);
    end else if (ign_cols) begin
      err_nxt = lesf_pkg::latch_err(err_nxt, lesf_pkg::ST_ROW_LEN);
    end else if (bad_char) begin
      err_nxt = lesf_pkg::latch_err(err_nxt, lesf_pkg::ST_BAD_CHAR);
    end

    col_after   = cellv ? col_cnt_r + CW'(1) : col_cnt_r;
    row_after   = row_cnt_r;
    col_cnt_nxt = col_after;
    frw_nxt     = frw_r;

    if (in_payload.row_end || in_payload.map_end) begin
      if (!in_payload.row_end) begin
        err_nxt = lesf_pkg::latch_err(err_nxt, lesf_pkg::ST_ROW_LEN);
      end
      if (row_cnt_r == '0) begin
        frw_nxt = col_after;
      end else if (col_after != frw_r) begin
        err_nxt = lesf_pkg::latch_err(err_nxt, lesf_pkg::ST_ROW_LEN);
      end
      if (row_cnt_r != lesf_pkg::ROWS_SAT) begin
        row_after = row_cnt_r + RW'(1);
      end
      col_cnt_nxt = '0;
    end
    row_cnt_nxt = row_after;

    if (in_payload.map_end) begin
      if ((row_after != expected_rows_r) || (32'(row_after) > MAX_ROWS)) begin
        err_nxt = lesf_pkg::latch_err(err_nxt, lesf_pkg::ST_ROW_COUNT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      frw_r     <= '0;
      err_r     <= lesf_pkg::ST_OK;
    end else if (in_acc) begin
      if (in_payload.map_end) begin
        // A finished map leaves the counters as after reset.
        col_cnt_r <= '0;
        row_cnt_r <= '0;
        frw_r     <= '0;
        err_r     <= lesf_pkg::ST_OK;
      end else begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
        frw_r     <= frw_nxt;
        err_r     <= err_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line buffer: read as the cell is accepted, written from the compute stage
  // --------------------------------------------------------------------------
  logic [SZW-1:0] above_mem [MAX_COLS];
  logic [SZW-1:0] mem_q;
  logic [SZW-1:0] sz;
  logic [AW-1:0]  rd_addr;

  assign rd_addr = col_cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      mem_q <= above_mem[rd_addr];
    end
    if (a_we) begin
      above_mem[a_r.col] <= sz;
    end
  end

  // Stage register; the bypass covers a read of the column being written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r.col    <= rd_addr;
      a_r.row    <= row_cnt_r;
      a_r.cellv  <= cellv;
      a_r.obs    <= is_obs || bad_char;
      a_r.row0   <= row_cnt_r == '0;
      a_r.rowend <= in_payload.row_end || in_payload.map_end;
      a_r.mapend <= in_payload.map_end;
      a_r.err    <= err_nxt;
      a_r.fwd    <= a_we && (a_r.col == rd_addr);
      a_r.fwd_sz <= sz;
    end
  end

  // --------------------------------------------------------------------------
  // Compute stage: square size at this corner and best-so-far update
  // --------------------------------------------------------------------------
  logic [SZW-1:0]            left_r, left_nxt;
  logic [SZW-1:0]            diag_r, diag_nxt;
  logic [SZW-1:0]            best_s_r, best_s_nxt;
  logic [lesf_pkg::POS_W-1:0] best_row_r, best_row_nxt;
  logic [lesf_pkg::POS_W-1:0] best_col_r, best_col_nxt;
  logic [SZW-1:0]            up, m01, m012;
  logic [31:0]               row_top, col_left;

  always_comb begin
    up   = a_r.row0 ? '0 : (a_r.fwd ? a_r.fwd_sz : mem_q);
    m01  = (left_r < up) ? left_r : up;
    m012 = (m01 < diag_r) ? m01 : diag_r;
    sz   = a_r.obs ? '0 : m012 + SZW'(1);

    row_top  = 32'(a_r.row) + 32'd1 - 32'(sz);
    col_left = 32'(a_r.col) + 32'd1 - 32'(sz);

    left_nxt     = left_r;
    diag_nxt     = diag_r;
    best_s_nxt   = best_s_r;
    best_row_nxt = best_row_r;
    best_col_nxt = best_col_r;
    if (a_r.cellv) begin
      diag_nxt = up;
      left_nxt = sz;
      if (sz > best_s_r) begin
        best_s_nxt   = sz;
        best_row_nxt = row_top[lesf_pkg::POS_W-1:0];
        best_col_nxt = col_left[lesf_pkg::POS_W-1:0];
      end
    end
    if (a_r.rowend) begin
      left_nxt = '0;
      diag_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= '0;
      diag_r     <= '0;
      best_s_r   <= '0;
      best_row_r <= '0;
      best_col_r <= '0;
    end else if (a_fire) begin
      if (a_r.mapend) begin
        left_r     <= '0;
        diag_r     <= '0;
        best_s_r   <= '0;
        best_row_r <= '0;
        best_col_r <= '0;
      end else begin
        left_r     <= left_nxt;
        diag_r     <= diag_nxt;
        best_s_r   <= best_s_nxt;
        best_row_r <= best_row_nxt;
        best_col_r <= best_col_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  lesf_pkg::out_item_t out_r;
  logic [31:0]         best_s_ext;

  assign best_s_ext = 32'(best_s_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_fire && a_r.mapend) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_r.mapend) begin
      out_r.status <= a_r.err;
      if (a_r.err == lesf_pkg::ST_OK) begin
        out_r.best_row  <= best_row_nxt;
        out_r.best_col  <= best_col_nxt;
        out_r.best_size <= best_s_ext[lesf_pkg::SIZE_W-1:0];
      end else begin
        out_r.best_row  <= '0;
        out_r.best_col  <= '0;
        out_r.best_size <= '0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && a_valid_r && a_r.mapend))
    else $error("input stalled without a blocked result");

  a_result_from_map_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(a_valid_r && a_r.mapend))
    else $error("result appeared without a map end in the compute stage");

  a_error_zeroes_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != lesf_pkg::ST_OK)) |->
      (out_r.best_row == '0 && out_r.best_col == '0 && out_r.best_size == '0))
    else $error("error result carries a nonzero square");

  a_map_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_payload.map_end) |=>
      (col_cnt_r == '0 && row_cnt_r == '0 && err_r == lesf_pkg::ST_OK))
    else $error("front counters not cleared after map end");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_cnt_r) <= MAX_COLS)
    else $error("column counter beyond the line buffer");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the largest empty square finder
// Streams character maps into the block and checks every result against a
// line-buffer predictor kept in the testbench. Starts with short hand-made
// maps, then runs random maps.
// The random maps are mostly well formed, with some noise and some broken
// ones. Both sides of the stream idle at random, and the registers change
// between groups of maps.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned COLS_MAX    = lesf_pkg::DEF_MAX_COLS;
  localparam int unsigned ROWS_MAX    = lesf_pkg::DEF_MAX_ROWS;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_CELLS = 1275;

  // Kinds of random map. Only the clean kind is always well formed.
  typedef enum int {
    MAP_CLEAN,
    MAP_BAD_CHAR,
    MAP_SHORT_ROW,
    MAP_ROWS_OFF,
    MAP_OPEN_END,
    MAP_NOISE
  } map_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Stream and register port signals; those driven here are known from time zero.
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  lesf_pkg::in_item_t              in_payload = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  lesf_pkg::out_item_t             out_payload;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [lesf_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [lesf_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [lesf_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  // Cells waiting to be sent and square reports still owed by the block.
  lesf_pkg::in_item_t  cell_queue[$];
  lesf_pkg::out_item_t owed_squares[$];

  int unsigned cells_queued = 0;
  int unsigned errors_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 68;
  bit          in_fire = 1'b0;

  // Shadow copy of the registers, updated as they are written.
  logic [lesf_pkg::CFG_CHAR_W-1:0] cfg_empty = lesf_pkg::RST_EMPTY_CHAR;
  logic [lesf_pkg::CFG_CHAR_W-1:0] cfg_obst  = lesf_pkg::RST_OBSTACLE_CHAR;
  logic [lesf_pkg::ROWS_W-1:0]     cfg_rows  = lesf_pkg::RST_EXPECTED_ROWS;

  // Predictor state: one square size per column for the row above, the
  // sizes to the left and above-left of the current cell, the position in
  // the map, the width of the first row, the best square so far and the
  // first error of the map.
  int unsigned       sq_above[COLS_MAX];
  int unsigned       sq_left;
  int unsigned       sq_diag;
  int unsigned       cur_col;
  int unsigned       cur_row;
  int unsigned       width_first;
  int unsigned       best_r;
  int unsigned       best_c;
  int unsigned       best_s;
  lesf_pkg::status_t map_status;

  largest_empty_square_finder_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Everything that belongs to one map returns to its start values at the
  // end of each map.
  function automatic void clear_map();
    for (int i = 0; i < COLS_MAX; i++) sq_above[i] = 0;
    sq_left = 0;
    sq_diag = 0;
    cur_col = 0;
    cur_row = 0;
    width_first = 0;
    best_r = 0;
    best_c = 0;
    best_s = 0;
    map_status = lesf_pkg::ST_OK;
  endfunction

  // Only the first error of a map is kept.
  function automatic void note_error(lesf_pkg::status_t code);
    if (map_status == lesf_pkg::ST_OK) map_status = code;
  endfunction

  // Advances the predictor by one cell. Returns 1 and the square report when
  // the cell closes the map.
  function automatic bit predict_square(input lesf_pkg::in_item_t item_in,
                                        output lesf_pkg::out_item_t rep);
    int unsigned col;
    int unsigned up;
    int unsigned sz;
    int unsigned m;
    bit          blocked;
    rep = '0;
    if (cur_row >= ROWS_MAX) begin
      // Cells past the last supported row are dropped.
      note_error(lesf_pkg::ST_ROW_COUNT);
    end else if (cur_col >= COLS_MAX) begin
      // Cells past the last supported column are dropped.
      note_error(lesf_pkg::ST_ROW_LEN);
    end else begin
      col = cur_col;
      blocked = (item_in.cell_char == {1'b0, cfg_obst});
      if (!blocked && item_in.cell_char != {1'b0, cfg_empty}) begin
        // Any other code, newline included, is an error and blocks the cell.
        note_error(lesf_pkg::ST_BAD_CHAR);
        blocked = 1'b1;
      end
      up = (cur_row != 0) ? sq_above[col] : 0;
      m = sq_left;
      if (up < m) m = up;
      if (sq_diag < m) m = sq_diag;
      sz = blocked ? 0 : m + 1;
      sq_diag = up;
      sq_left = sz;
      sq_above[col] = sz;
      // Strictly larger only, so ties keep the earliest corner.
      if (sz > best_s) begin
        best_s = sz;
        best_r = cur_row + 1 - sz;
        best_c = col + 1 - sz;
      end
      cur_col = col + 1;
    end
    if (item_in.row_end || item_in.map_end) begin
      if (!item_in.row_end) note_error(lesf_pkg::ST_ROW_LEN);
      if (cur_row == 0) width_first = cur_col;
      else if (cur_col != width_first) note_error(lesf_pkg::ST_ROW_LEN);
      if (cur_row < lesf_pkg::ROWS_SAT) cur_row++;
      cur_col = 0;
      sq_left = 0;
      sq_diag = 0;
    end
    if (!item_in.map_end) return 1'b0;
    if (cur_row != cfg_rows || cur_row > ROWS_MAX) note_error(lesf_pkg::ST_ROW_COUNT);
    if (map_status == lesf_pkg::ST_OK) begin
      rep.best_row  = best_r[lesf_pkg::POS_W-1:0];
      rep.best_col  = best_c[lesf_pkg::POS_W-1:0];
      rep.best_size = best_s[lesf_pkg::SIZE_W-1:0];
    end
    rep.status = map_status;
    clear_map();
    return 1'b1;
  endfunction

  // Driver. Inputs change on the falling edge. A stalled item is held as it
  // is; otherwise the next cell goes out unless the sender takes a gap.
  always @(negedge clk) begin
    bit gap;
    gap = ($urandom_range(0, 99) < send_idle_pct);
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_fire)) begin
      if (!gap && cell_queue.size() != 0) begin
        in_valid   <= 1'b1;
        in_payload <= cell_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor. Both channels are sampled at the rising edge. Each report is
  // checked against the oldest one owed, and each accepted cell is fed to
  // the predictor.
  always @(posedge clk) begin
    lesf_pkg::out_item_t want;
    lesf_pkg::out_item_t got;
    lesf_pkg::out_item_t rep;
    in_fire = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = out_payload;
        if (owed_squares.size() == 0) begin
          $error("unexpected result: row %0d col %0d size %0d status %0d",
                 got.best_row, got.best_col, got.best_size, got.status);
          errors_seen++;
        end else begin
          want = owed_squares.pop_front();
          if (got.best_row !== want.best_row) begin
            $error("best_row mismatch: expected %0d, actual %0d", want.best_row, got.best_row);
            errors_seen++;
          end
          if (got.best_col !== want.best_col) begin
            $error("best_col mismatch: expected %0d, actual %0d", want.best_col, got.best_col);
            errors_seen++;
          end
          if (got.best_size !== want.best_size) begin
            $error("best_size mismatch: expected %0d, actual %0d",
                   want.best_size, got.best_size);
            errors_seen++;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            errors_seen++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_fire = 1'b1;
        if (predict_square(in_payload, rep)) owed_squares.push_back(rep);
      end
    end
  end

  task automatic put_cell(input logic [lesf_pkg::CHAR_W-1:0] ch, input bit re, input bit me);
    lesf_pkg::in_item_t item;
    item.cell_char = ch;
    item.row_end   = re;
    item.map_end   = me;
    cell_queue.push_back(item);
    cells_queued++;
  endtask

  // Waits until every cell has gone in and every report has come out, then
  // waits on so the block is surely at rest.
  task automatic wait_idle();
    while (cell_queue.size() != 0 || in_valid || owed_squares.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes one register with a setup and an access phase, reads it back and
  // updates the shadow copy.
  task automatic write_reg(input lesf_pkg::reg_idx_t idx,
                           input logic [lesf_pkg::APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $error("register %0d readback mismatch: expected %0d, actual %0d", idx, value, prdata);
      errors_seen++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      lesf_pkg::REG_EMPTY_CHAR:    cfg_empty = value[lesf_pkg::CFG_CHAR_W-1:0];
      lesf_pkg::REG_OBSTACLE_CHAR: cfg_obst  = value[lesf_pkg::CFG_CHAR_W-1:0];
      lesf_pkg::REG_EXPECTED_ROWS: cfg_rows  = value[lesf_pkg::ROWS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned e, input int unsigned o, input int unsigned rows);
    wait_idle();
    write_reg(lesf_pkg::REG_EMPTY_CHAR, e);
    write_reg(lesf_pkg::REG_OBSTACLE_CHAR, o);
    write_reg(lesf_pkg::REG_EXPECTED_ROWS, rows);
  endtask

  // Queues one random map of the given shape. No row after the first is
  // ever longer than the first, so the line buffer is only read where the
  // rows above of the same map have written it.
  task automatic gen_map(input int unsigned rows, input int unsigned width,
                         input map_kind_t kind_in);
    map_kind_t                   kind;
    int unsigned                 n_rows;
    int unsigned                 len;
    int unsigned                 odd_r;
    int unsigned                 odd_c;
    int unsigned                 obst_pct;
    logic [lesf_pkg::CHAR_W-1:0] ch;
    bit                          last;
    kind = kind_in;
    // A short row needs a second row and room to be shorter.
    if (kind == MAP_SHORT_ROW && (rows < 2 || width < 2)) kind = MAP_OPEN_END;
    n_rows = rows;
    if (kind == MAP_ROWS_OFF) begin
      if (rows <= 1 || $urandom_range(0, 1) == 1) n_rows = rows + $urandom_range(1, 2);
      else n_rows = rows - 1;
    end
    obst_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
    odd_r = (kind == MAP_SHORT_ROW) ? $urandom_range(1, n_rows - 1)
                                    : $urandom_range(0, n_rows - 1);
    odd_c = $urandom_range(0, width - 1);
    for (int r = 0; r < n_rows; r++) begin
      len = width;
      if (kind == MAP_SHORT_ROW && r == odd_r) len = $urandom_range(1, width - 1);
      if (kind == MAP_OPEN_END && r == n_rows - 1) len = $urandom_range(1, width);
      for (int c = 0; c < len; c++) begin
        if (kind == MAP_NOISE && $urandom_range(0, 3) == 0) begin
          ch = lesf_pkg::CHAR_W'($urandom_range(0, 255));
        end else if ($urandom_range(0, 99) < obst_pct) begin
          ch = {1'b0, cfg_obst};
        end else begin
          ch = {1'b0, cfg_empty};
        end
        if (kind == MAP_BAD_CHAR && r == odd_r && c == odd_c) begin
          case ($urandom_range(0, 2))
            0:       ch = 8'h0A;
            1:       ch = {1'b1, cfg_empty};
            default: ch = lesf_pkg::CHAR_W'($urandom_range(0, 255));
          endcase
        end
        last = (r == n_rows - 1) && (c == len - 1);
        put_cell(ch, (c == len - 1) && !(last && kind == MAP_OPEN_END), last);
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    logic [lesf_pkg::CHAR_W-1:0] ec;
    logic [lesf_pkg::CHAR_W-1:0] oc;
    int unsigned                 e;
    int unsigned                 o;
    int unsigned                 rows;
    int unsigned                 pick;
    int unsigned                 start_cells;
    int unsigned                 done_cells;
    map_kind_t                   kind;

    clear_map();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Hand-made maps with the register values left by reset.
    ec = {1'b0, cfg_empty};
    oc = {1'b0, cfg_obst};
    put_cell(ec, 1, 1);                    // single empty cell
    put_cell(oc, 1, 1);                    // no empty cell at all
    put_cell(8'h0A, 1, 1);                 // newline is a bad character
    put_cell({1'b1, cfg_empty}, 1, 1);     // empty code with the top bit set
    put_cell(8'h00, 0, 0);
    put_cell(8'hFF, 1, 1);
    put_cell(ec, 0, 1);                    // map ends without a row end
    put_cell(oc, 0, 0);                    // tie: the leftmost square wins
    put_cell(ec, 0, 0);
    put_cell(ec, 0, 0);
    put_cell(oc, 0, 0);
    put_cell(ec, 1, 1);
    put_cell(ec, 1, 0);                    // two rows where one is expected
    put_cell(ec, 1, 1);

    // Character codes at both ends of their range, two rows expected.
    set_config(126, 32, 2);
    ec = {1'b0, cfg_empty};
    oc = {1'b0, cfg_obst};
    put_cell(oc, 0, 0);                    // a 2x2 square right of an obstacle
    put_cell(ec, 0, 0);
    put_cell(ec, 1, 0);
    put_cell(ec, 0, 0);
    put_cell(ec, 0, 0);
    put_cell(ec, 1, 1);
    put_cell(ec, 0, 0);                    // second row shorter than the first
    put_cell(ec, 1, 0);
    put_cell(ec, 1, 1);

    // Both codes equal: a matching cell is an obstacle.
    set_config(77, 77, 1);
    put_cell(8'd77, 0, 0);
    put_cell(8'd77, 1, 1);

    // Random groups of maps. Each group gets fresh register values; the
    // idling pattern moves through its three phases as the cells go out.
    start_cells = cells_queued;
    done_cells = 0;
    while (done_cells < RANDOM_CELLS) begin
      case (done_cells * 3 / RANDOM_CELLS)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      e = $urandom_range(32, 126);
      o = $urandom_range(32, 126);
      case ($urandom_range(0, 9))
        0: o = e;
        1: begin
          e = 32;
          o = 126;
        end
        2: begin
          e = 126;
          o = 32;
        end
        default: ;
      endcase
      rows = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 5);
      set_config(e, o, rows);
      repeat ($urandom_range(4, 10)) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      kind = MAP_CLEAN;
        else if (pick < 76) kind = MAP_BAD_CHAR;
        else if (pick < 82) kind = MAP_SHORT_ROW;
        else if (pick < 88) kind = MAP_ROWS_OFF;
        else if (pick < 94) kind = MAP_OPEN_END;
        else                kind = MAP_NOISE;
        gen_map(rows, ($urandom_range(0, 19) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 8), kind);
      end
      done_cells = cells_queued - start_cells;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors_seen == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
